>>> rtl/phong_point_light_shader_top_assert.svh
`ifndef PHONG_POINT_LIGHT_SHADER_TOP_ASSERT_SVH
`define PHONG_POINT_LIGHT_SHADER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PPLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition now implies result on the next edge
`define PPLS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

>>> rtl/ppls_pkg.sv
package ppls_pkg;

  localparam int VEC_W     = 42;
  localparam int UNIT_W    = 32;
  localparam int UNIT_FRAC = 30;
  localparam int MAG_W     = 30;
  localparam int SQ_W      = 62;
  localparam int ROOT_W    = 31;
  localparam int QUO_W     = 31;
  localparam int DOT_W     = 34;
  localparam int P2_W      = 32;
  localparam int CH_W      = 16;
  localparam int GAIN_W    = 48;

  localparam int STG_STEPS = 4;
  localparam int ISQ_ITER  = 31;
  localparam int DIV_ITER  = 31;
  localparam int ISQ_STG   = (ISQ_ITER + STG_STEPS - 1) / STG_STEPS;
  localparam int DIV_STG   = (DIV_ITER + STG_STEPS - 1) / STG_STEPS;
  localparam int NORM_LAT  = 3 + ISQ_STG + DIV_STG + 1;
  localparam int PIPE_LAT  = 2 * NORM_LAT + 12;

  localparam int ADDR_W    = 6;
  localparam int REG_SHIFT = 3;
  localparam int DATA_W    = 64;

  typedef enum logic [2:0] {
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z,
    REG_LIGHT_R,
    REG_LIGHT_G,
    REG_LIGHT_B,
    REG_GAINS
  } reg_idx_e;

  localparam logic [GAIN_W-1:0] GAINS_RST = 48'd56294673226138;
  localparam logic [CH_W-1:0]   LIGHT_RST = 16'd4096;

  typedef logic [2:0][VEC_W-1:0]  vec_t;
  typedef logic [2:0][UNIT_W-1:0] unit_t;
  typedef logic [2:0][CH_W-1:0]   chan_t;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic [15:0]        object_red;
    logic [15:0]        object_green;
    logic [15:0]        object_blue;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] shade_red;
    logic signed [31:0] shade_green;
    logic signed [31:0] shade_blue;
  } out_item_t;

endpackage

>>> rtl/ppls_isqrt.sv
module ppls_isqrt import ppls_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   x_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = 36;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   xs;
  } isq_st_t;

  function automatic isq_st_t isq_step(isq_st_t a);
    isq_st_t          r;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    rem2  = {a.rem[REM_W-3:0], a.xs[SQ_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, a.root, 2'b01};
    r.xs  = {a.xs[SQ_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  isq_st_t prev [ISQ_STG];
  isq_st_t st_d [ISQ_STG];
  isq_st_t st_q [ISQ_STG];

  for (genvar s = 0; s < ISQ_STG; s++) begin : g_stg
    if (s == 0) begin : g_first
      assign prev[s] = '{rem: '0, root: '0, xs: x_i};
    end else begin : g_next
      assign prev[s] = st_q[s-1];
    end

    // up to STG_STEPS digit steps per register stage
    always_comb begin
      st_d[s] = prev[s];
      for (int k = 0; k < STG_STEPS; k++) begin
        if (s * STG_STEPS + k < ISQ_ITER) begin
          st_d[s] = isq_step(st_d[s]);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign root_o = st_q[ISQ_STG-1].root;

endmodule

>>> rtl/ppls_div.sv
module ppls_div import ppls_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MAG_W-1:0]  mag_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [QUO_W-1:0]  quo_o
);

  localparam int REM_W = ROOT_W + 1;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    logic [ROOT_W-1:0] den;
  } div_st_t;

  // mag never exceeds den, so the first step compares mag itself
  function automatic div_st_t div_step(div_st_t a, logic first);
    div_st_t          r;
    logic [REM_W-1:0] rem2;
    rem2  = first ? a.rem : {a.rem[REM_W-2:0], 1'b0};
    r.den = a.den;
    if (rem2 >= {1'b0, a.den}) begin
      r.rem = rem2 - {1'b0, a.den};
      r.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = rem2;
      r.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  div_st_t prev [DIV_STG];
  div_st_t st_d [DIV_STG];
  div_st_t st_q [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    if (s == 0) begin : g_first
      assign prev[s] = '{rem: REM_W'(mag_i), quo: '0, den: den_i};
    end else begin : g_next
      assign prev[s] = st_q[s-1];
    end

    always_comb begin
      st_d[s] = prev[s];
      for (int k = 0; k < STG_STEPS; k++) begin
        if (s * STG_STEPS + k < DIV_ITER) begin
          st_d[s] = div_step(st_d[s], (s * STG_STEPS + k) == 0);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign quo_o = st_q[DIV_STG-1].quo;

endmodule

>>> rtl/ppls_norm.sv
module ppls_norm import ppls_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  vec_t  vec_i,
  output unit_t unit_o
);

  localparam int AMAG_W  = VEC_W - 1;
  localparam int POS_W   = $clog2(AMAG_W);
  localparam int TOP_POS = MAG_W - 1;
  localparam int SIDE_DL = ISQ_STG + DIV_STG;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } side_t;

  typedef logic [2:0][MAG_W-1:0] mag3_t;

  logic [AMAG_W-1:0] mag [3];
  logic [AMAG_W-1:0] mmax;
  logic [POS_W-1:0]  pos;
  mag3_t             sc_d;
  side_t             side_d;

  // scale so the largest magnitude has its top bit at TOP_POS
  always_comb begin
    mmax = '0;
    pos  = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][VEC_W-1] ? AMAG_W'(-vec_i[i]) : AMAG_W'(vec_i[i]);
      if (mag[i] > mmax) begin
        mmax = mag[i];
      end
    end
    for (int b = 0; b < AMAG_W; b++) begin
      if (mmax[b]) begin
        pos = POS_W'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (pos > TOP_POS) begin
        sc_d[i] = MAG_W'(mag[i] >> (pos - TOP_POS));
      end else begin
        sc_d[i] = MAG_W'(mag[i] << (TOP_POS - pos));
      end
      side_d.neg[i] = vec_i[i][VEC_W-1];
    end
    side_d.zero = (mmax == '0);
  end

  mag3_t                       sc1_q, sc2_q, sc3_q;
  side_t                       side1_q, side2_q, side3_q;
  logic [2:0][2*MAG_W-1:0]     sq2_q;
  logic [SQ_W-1:0]             sum3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc1_q   <= sc_d;
      side1_q <= side_d;
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= (2*MAG_W)'(sc1_q[i]) * (2*MAG_W)'(sc1_q[i]);
      end
      sc2_q   <= sc1_q;
      side2_q <= side1_q;
      sum3_q  <= SQ_W'(sq2_q[0]) + SQ_W'(sq2_q[1]) + SQ_W'(sq2_q[2]);
      sc3_q   <= sc2_q;
      side3_q <= side2_q;
    end
  end

  logic [ROOT_W-1:0] root;

  ppls_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .x_i    (sum3_q),
    .root_o (root)
  );

  mag3_t sc_dl_q   [ISQ_STG];
  side_t side_dl_q [SIDE_DL];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_dl_q[0]   <= sc3_q;
      side_dl_q[0] <= side3_q;
      for (int k = 1; k < ISQ_STG; k++) begin
        sc_dl_q[k] <= sc_dl_q[k-1];
      end
      for (int k = 1; k < SIDE_DL; k++) begin
        side_dl_q[k] <= side_dl_q[k-1];
      end
    end
  end

  logic [QUO_W-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    ppls_div u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .mag_i (sc_dl_q[ISQ_STG-1][i]),
      .den_i (root),
      .quo_o (quo[i])
    );
  end

  unit_t unit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (side_dl_q[SIDE_DL-1].zero) begin
          unit_q[i] <= '0;
        end else if (side_dl_q[SIDE_DL-1].neg[i]) begin
          unit_q[i] <= UNIT_W'(0) - UNIT_W'(quo[i]);
        end else begin
          unit_q[i] <= UNIT_W'(quo[i]);
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule

>>> rtl/ppls_shade.sv
module ppls_shade import ppls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [DOT_W-1:0] d_i,
  input  logic [P2_W-1:0]         p2_i,
  input  chan_t                   col_i,
  input  chan_t                   lrad_i,
  input  logic [GAIN_W-1:0]       gains_i,
  output out_item_t               out_o
);

  localparam int LC_W  = 2 * CH_W;
  localparam int AMB_W = 42;
  localparam int KDL_W = 30;
  localparam int SPC_W = 40;
  localparam int ACC_W = 48;
  localparam int DP_W  = KDL_W + DOT_W + 1;

  logic [CH_W-1:0] ka, kd, ks;
  assign ka = gains_i[47:32];
  assign kd = gains_i[31:16];
  assign ks = gains_i[15:0];

  // stage 1: light times color, specular gain times light
  logic [LC_W-1:0]         lc_q  [3];
  logic [LC_W-1:0]         ksl_q [3];
  logic signed [DOT_W-1:0] d1_q, d2_q;
  logic [P2_W-1:0]         p21_q;

  // stage 2: the three terms before the diffuse multiply
  logic [AMB_W-1:0] amb2_q [3];
  logic [KDL_W-1:0] kdl2_q [3];
  logic [SPC_W-1:0] spc2_q [3];

  // stage 3: diffuse term
  logic signed [DP_W-1:0]  dprd [3];
  logic signed [ACC_W-1:0] dif3_q [3];
  logic [AMB_W-1:0]        amb3_q [3];
  logic [SPC_W-1:0]        spc3_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dprd[c] = $signed({{(DP_W-KDL_W){1'b0}}, kdl2_q[c]})
              * $signed({{(DP_W-DOT_W){d2_q[DOT_W-1]}}, d2_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        lc_q[c]   <= LC_W'(lrad_i[c]) * LC_W'(col_i[c]);
        ksl_q[c]  <= LC_W'(ks) * LC_W'(lrad_i[c]);
        amb2_q[c] <= AMB_W'((GAIN_W'(ka) * GAIN_W'(lc_q[c])) >> 6);
        kdl2_q[c] <= KDL_W'((GAIN_W'(kd) * GAIN_W'(lc_q[c])) >> 18);
        spc2_q[c] <= SPC_W'((64'(ksl_q[c]) * 64'(p21_q)) >> 24);
        dif3_q[c] <= ACC_W'(dprd[c] >>> 18);
        amb3_q[c] <= amb2_q[c];
        spc3_q[c] <= spc2_q[c];
      end
      d1_q  <= d_i;
      p21_q <= p2_i;
      d2_q  <= d1_q;
    end
  end

  // stage 4: sum, scale and saturate
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] shv [3];
  logic [31:0]             sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = $signed(ACC_W'(amb3_q[c])) + dif3_q[c] + $signed(ACC_W'(spc3_q[c]));
      shv[c] = acc[c] >>> 16;
      if (shv[c] > $signed(ACC_W'(32'h7fff_ffff))) begin
        sat[c] = 32'h7fff_ffff;
      end else if (shv[c] < -$signed(ACC_W'(33'h1_0000_0000 >> 1))) begin
        sat[c] = 32'h8000_0000;
      end else begin
        sat[c] = shv[c][31:0];
      end
    end
  end

  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.shade_red   <= sat[0];
      out_q.shade_green <= sat[1];
      out_q.shade_blue  <= sat[2];
    end
  end

  assign out_o = out_q;

endmodule

>>> rtl/phong_point_light_shader_top.sv
// Phong shader for one point light: each item (hit point, normal, ray origin,
// object color) yields one shaded color, ambient plus unclamped diffuse plus a
// white specular term with exponent two, saturated to signed Q14.18. It takes
// one item per clock cycle unless the output stalls; most of its depth is the
// two vector normalizations in series, each an 8-stage square root and an
// 8-stage divider, up to four result bits per stage. A stalled output holds the
// whole pipeline, nothing is dropped. Light position, radiance and gains sit on
// the APB port; rewrite them only with no item in flight (not enforced here).
module phong_point_light_shader_top import ppls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int NU_DL  = 2;
  localparam int SU_DL  = 3;
  localparam int VU_DL  = NORM_LAT + 4;
  localparam int D_DL   = NORM_LAT + 5;
  localparam int COL_DL = 2 * NORM_LAT + 7;

  // configuration registers
  logic signed [31:0] light_x_q, light_y_q, light_z_q;
  logic [CH_W-1:0]    light_r_q, light_g_q, light_b_q;
  logic [GAIN_W-1:0]  gains_q;
  logic               cfg_wr;
  reg_idx_e           cidx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cidx   = reg_idx_e'(paddr[ADDR_W-1:REG_SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= '0;
      light_y_q <= '0;
      light_z_q <= '0;
      light_r_q <= LIGHT_RST;
      light_g_q <= LIGHT_RST;
      light_b_q <= LIGHT_RST;
      gains_q   <= GAINS_RST;
    end else if (cfg_wr) begin
      unique case (cidx)
        REG_LIGHT_X: light_x_q <= pwdata[31:0];
        REG_LIGHT_Y: light_y_q <= pwdata[31:0];
        REG_LIGHT_Z: light_z_q <= pwdata[31:0];
        REG_LIGHT_R: light_r_q <= pwdata[CH_W-1:0];
        REG_LIGHT_G: light_g_q <= pwdata[CH_W-1:0];
        REG_LIGHT_B: light_b_q <= pwdata[CH_W-1:0];
        REG_GAINS:   gains_q   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cidx)
      REG_LIGHT_X: prdata = DATA_W'(light_x_q);
      REG_LIGHT_Y: prdata = DATA_W'(light_y_q);
      REG_LIGHT_Z: prdata = DATA_W'(light_z_q);
      REG_LIGHT_R: prdata = DATA_W'(light_r_q);
      REG_LIGHT_G: prdata = DATA_W'(light_g_q);
      REG_LIGHT_B: prdata = DATA_W'(light_b_q);
      REG_GAINS:   prdata = DATA_W'(gains_q);
      default:     prdata = '0;
    endcase
  end

  // pipeline control: everything advances unless the output item is stuck
  logic [PIPE_LAT-1:0] vld_q;
  logic                en;

  assign en          = !vld_q[PIPE_LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // input stage: light and view vectors relative to the hit point
  vec_t  nv_q, sv_q, vv_q;
  chan_t col0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nv_q[0] <= VEC_W'(in_data_i.normal_x);
      nv_q[1] <= VEC_W'(in_data_i.normal_y);
      nv_q[2] <= VEC_W'(in_data_i.normal_z);
      sv_q[0] <= VEC_W'(light_x_q) - VEC_W'(in_data_i.hit_x);
      sv_q[1] <= VEC_W'(light_y_q) - VEC_W'(in_data_i.hit_y);
      sv_q[2] <= VEC_W'(light_z_q) - VEC_W'(in_data_i.hit_z);
      vv_q[0] <= VEC_W'(in_data_i.eye_x) - VEC_W'(in_data_i.hit_x);
      vv_q[1] <= VEC_W'(in_data_i.eye_y) - VEC_W'(in_data_i.hit_y);
      vv_q[2] <= VEC_W'(in_data_i.eye_z) - VEC_W'(in_data_i.hit_z);
      col0_q  <= {in_data_i.object_blue, in_data_i.object_green, in_data_i.object_red};
    end
  end

  unit_t nu, su, vu, ru;

  ppls_norm u_norm_n (.clk_i(clk_i), .en_i(en), .vec_i(nv_q), .unit_o(nu));
  ppls_norm u_norm_s (.clk_i(clk_i), .en_i(en), .vec_i(sv_q), .unit_o(su));
  ppls_norm u_norm_v (.clk_i(clk_i), .en_i(en), .vec_i(vv_q), .unit_o(vu));

  // d = S.N, then R = 2(S.N)N - S
  logic signed [2*UNIT_W-1:0]     dprod_q [3];
  logic signed [2*UNIT_W+1:0]     dsum;
  logic signed [DOT_W-1:0]        d_q;
  logic signed [DOT_W+UNIT_W-1:0] rprod_q [3];
  vec_t                           rv_q;
  unit_t                          nu_dl_q [NU_DL];
  unit_t                          su_dl_q [SU_DL];
  unit_t                          vu_dl_q [VU_DL];
  logic signed [DOT_W-1:0]        d_dl_q  [D_DL];
  chan_t                          col_dl_q [COL_DL];

  assign dsum = (2*UNIT_W+2)'(dprod_q[0]) + (2*UNIT_W+2)'(dprod_q[1])
              + (2*UNIT_W+2)'(dprod_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dprod_q[i] <= $signed(su[i]) * $signed(nu[i]);
        rprod_q[i] <= d_q * $signed(nu_dl_q[NU_DL-1][i]);
        rv_q[i]    <= VEC_W'(rprod_q[i] >>> (UNIT_FRAC - 1))
                    - VEC_W'($signed(su_dl_q[SU_DL-1][i]));
      end
      d_q <= DOT_W'(dsum >>> UNIT_FRAC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nu_dl_q[0]  <= nu;
      su_dl_q[0]  <= su;
      vu_dl_q[0]  <= vu;
      d_dl_q[0]   <= d_q;
      col_dl_q[0] <= col0_q;
      for (int k = 1; k < NU_DL; k++) nu_dl_q[k] <= nu_dl_q[k-1];
      for (int k = 1; k < SU_DL; k++) su_dl_q[k] <= su_dl_q[k-1];
      for (int k = 1; k < VU_DL; k++) vu_dl_q[k] <= vu_dl_q[k-1];
      for (int k = 1; k < D_DL; k++) d_dl_q[k] <= d_dl_q[k-1];
      for (int k = 1; k < COL_DL; k++) col_dl_q[k] <= col_dl_q[k-1];
    end
  end

  ppls_norm u_norm_r (.clk_i(clk_i), .en_i(en), .vec_i(rv_q), .unit_o(ru));

  // p = R.V and its square
  localparam int PSQ_W = 2 * DOT_W;

  logic signed [2*UNIT_W-1:0] pprod_q [3];
  logic signed [2*UNIT_W+1:0] psum;
  logic signed [DOT_W-1:0]    p_q;
  logic [DOT_W-1:0]           pmag;
  logic [PSQ_W-1:0]           psq;
  logic [P2_W-1:0]            p2_q;

  assign psum = (2*UNIT_W+2)'(pprod_q[0]) + (2*UNIT_W+2)'(pprod_q[1])
              + (2*UNIT_W+2)'(pprod_q[2]);
  assign pmag = p_q[DOT_W-1] ? DOT_W'(-p_q) : DOT_W'(p_q);
  assign psq  = PSQ_W'(pmag) * PSQ_W'(pmag);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pprod_q[i] <= $signed(ru[i]) * $signed(vu_dl_q[VU_DL-1][i]);
      end
      p_q  <= DOT_W'(psum >>> UNIT_FRAC);
      p2_q <= P2_W'(psq >> UNIT_FRAC);
    end
  end

  ppls_shade u_shade (
    .clk_i   (clk_i),
    .en_i    (en),
    .d_i     (d_dl_q[D_DL-1]),
    .p2_i    (p2_q),
    .col_i   (col_dl_q[COL_DL-1]),
    .lrad_i  ({light_b_q, light_g_q, light_r_q}),
    .gains_i (gains_q),
    .out_o   (out_data_o)
  );

endmodule

>>> rtl/ppls_checker.sv
`include "phong_point_light_shader_top_assert.svh"

module ppls_checker import ppls_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input out_item_t         out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  localparam logic [ADDR_W-1:0] LRED_ADDR = {REG_LIGHT_R, REG_SHIFT'(0)};

  logic red_wr;
  assign red_wr = psel && penable && pwrite && pready && (paddr == LRED_ADDR);

  // a drained output never blocks the input
  `PPLS_ASSERT(a_ready_when_taken, out_ready_i |-> in_ready_o, "input blocked with output taken")
  // the pipeline only stalls behind a waiting item
  `PPLS_ASSERT(a_stall_needs_item, !in_ready_o |-> out_valid_o, "stall without output item")
  `PPLS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "output item changed while stalled")
  // radiance write is visible on the next read
  `PPLS_ASSERT(a_cfg_readback, $past(red_wr) && $past(rst_ni) && paddr == LRED_ADDR |-> prdata[15:0] == $past(pwdata[15:0]), "radiance readback mismatch")

endmodule

bind phong_point_light_shader_top ppls_checker u_ppls_checker (.*);
